// ----- hdl/g711cc_pkg.sv -----
`default_nettype none
package g711cc_pkg;

   localparam logic [2:0] CMD_LIN_TO_A = 3'd0;
   localparam logic [2:0] CMD_LIN_TO_MU = 3'd1;
   localparam logic [2:0] CMD_A_TO_LIN = 3'd2;
   localparam logic [2:0] CMD_MU_TO_LIN = 3'd3;
   localparam logic [2:0] CMD_A_TO_MU = 3'd4;
   localparam logic [2:0] CMD_MU_TO_A = 3'd5;

   localparam logic [7:0] MASK_A_POS = 8'hD5;
   localparam logic [7:0] MASK_A_NEG = 8'h55;
   localparam logic [7:0] MASK_MU_NEG = 8'h7F;
   localparam logic [7:0] MASK_MU_POS = 8'hFF;
   localparam logic [7:0] TOP_CODE = 8'h7F;
   localparam logic [6:0] A_INDEX_FLIP = 7'h55;

   localparam logic [13:0] MU_CLIP = 14'd8159;
   localparam logic [13:0] MU_ENC_BIAS = 14'd33;
   localparam logic [14:0] A_DEC_BIAS = 15'h108;
   localparam logic [14:0] MU_DEC_BIAS = 15'h84;

   localparam int A_FIRST_END = 32;
   localparam int MU_FIRST_END = 64;

   localparam logic [6:0] A_TO_MU_TAB [128] = '{
      7'd1,   7'd3,   7'd5,   7'd7,   7'd9,   7'd11,  7'd13,  7'd15,
      7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,  7'd23,
      7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd29,  7'd30,  7'd31,
      7'd32,  7'd32,  7'd33,  7'd33,  7'd34,  7'd34,  7'd35,  7'd35,
      7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
      7'd44,  7'd45,  7'd46,  7'd47,  7'd48,  7'd48,  7'd49,  7'd49,
      7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,
      7'd58,  7'd59,  7'd60,  7'd61,  7'd62,  7'd63,  7'd64,  7'd64,
      7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,  7'd71,  7'd72,
      7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd79,
      7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
      7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,
      7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
      7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
      7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
      7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
   };

   // mu-law to A-law, stored already decremented by one
   localparam logic [6:0] MU_TO_A_TAB [128] = '{
      7'd0,   7'd0,   7'd1,   7'd1,   7'd2,   7'd2,   7'd3,   7'd3,
      7'd4,   7'd4,   7'd5,   7'd5,   7'd6,   7'd6,   7'd7,   7'd7,
      7'd8,   7'd9,   7'd10,  7'd11,  7'd12,  7'd13,  7'd14,  7'd15,
      7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,  7'd23,
      7'd24,  7'd26,  7'd28,  7'd30,  7'd32,  7'd33,  7'd34,  7'd35,
      7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
      7'd45,  7'd47,  7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,
      7'd54,  7'd55,  7'd56,  7'd57,  7'd58,  7'd59,  7'd60,  7'd61,
      7'd63,  7'd64,  7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,
      7'd71,  7'd72,  7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,
      7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
      7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,
      7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
      7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
      7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
      7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
   };

   // first stage to segment stage
   typedef struct packed {
      logic [2:0]  cmd;
      logic [13:0] mag;
      logic [7:0]  mask;
      logic [6:0]  xcode;
      logic        dec_neg;
      logic [2:0]  dec_seg;
      logic [3:0]  dec_mant;
   } prep_type;

   // segment stage to output stage
   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  mask;
      logic [14:0] pcm_mag;
      logic        pcm_neg;
   } seg_type;

endpackage
`default_nettype wire

// ----- hdl/g711cc_prep.sv -----
`default_nettype none
module g711cc_prep (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_stall,
   input  wire logic [2:0]         command,
   input  wire logic signed [15:0] sample,
   input  wire logic [7:0]         code_in,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output g711cc_pkg::prep_type    out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   g711cc_pkg::prep_type data_ff;
   g711cc_pkg::prep_type data_in;

   logic signed [12:0] va;
   logic signed [13:0] vm;
   logic [13:0]        mag_a;
   logic [13:0]        mag_m;
   logic [13:0]        clip_m;
   logic [7:0]         a_dec;
   logic [7:0]         u_dec;

   always_comb begin
      va = sample[15:3];
      vm = sample[15:2];
      // ones complement of a negative value gives -v - 1
      mag_a = va[12] ? {2'b00, ~va[11:0]} : {2'b00, va[11:0]};
      mag_m = vm[13] ? 14'(-vm) : 14'(vm);
      clip_m = (mag_m > g711cc_pkg::MU_CLIP) ? g711cc_pkg::MU_CLIP : mag_m;
      a_dec = code_in ^ g711cc_pkg::MASK_A_NEG;
      u_dec = ~code_in;

      data_in = '0;
      data_in.cmd = command;
      case (command)
         g711cc_pkg::CMD_LIN_TO_A: begin
            data_in.mag = mag_a;
            data_in.mask = va[12] ? g711cc_pkg::MASK_A_NEG : g711cc_pkg::MASK_A_POS;
         end
         g711cc_pkg::CMD_LIN_TO_MU: begin
            data_in.mag = clip_m + g711cc_pkg::MU_ENC_BIAS;
            data_in.mask = vm[13] ? g711cc_pkg::MASK_MU_NEG : g711cc_pkg::MASK_MU_POS;
         end
         g711cc_pkg::CMD_A_TO_LIN: begin
            data_in.dec_neg = ~a_dec[7];
            data_in.dec_seg = a_dec[6:4];
            data_in.dec_mant = a_dec[3:0];
         end
         g711cc_pkg::CMD_MU_TO_LIN: begin
            data_in.dec_neg = u_dec[7];
            data_in.dec_seg = u_dec[6:4];
            data_in.dec_mant = u_dec[3:0];
         end
         g711cc_pkg::CMD_A_TO_MU: begin
            data_in.xcode = g711cc_pkg::A_TO_MU_TAB[code_in[6:0] ^ g711cc_pkg::A_INDEX_FLIP];
            data_in.mask = code_in[7] ? g711cc_pkg::MASK_MU_POS : g711cc_pkg::MASK_MU_NEG;
         end
         g711cc_pkg::CMD_MU_TO_A: begin
            data_in.xcode = g711cc_pkg::MU_TO_A_TAB[~code_in[6:0]];
            data_in.mask = code_in[7] ? g711cc_pkg::MASK_A_POS : g711cc_pkg::MASK_A_NEG;
         end
         default: begin
         end
      endcase
   end

   assign in_stall = valid_ff & out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule
`default_nettype wire

// ----- hdl/g711cc_seg.sv -----
`default_nettype none
module g711cc_seg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire g711cc_pkg::prep_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output g711cc_pkg::seg_type       out_data
);

   logic                valid_ff;
   logic                valid_in;
   g711cc_pkg::seg_type data_ff;
   g711cc_pkg::seg_type data_in;

   logic [3:0]  seg_a;
   logic [3:0]  seg_m;
   logic [3:0]  sh_a;
   logic [3:0]  sh_m;
   logic [3:0]  mant_a;
   logic [3:0]  mant_m;
   logic [14:0] a_base;
   logic [14:0] a_t;
   logic [14:0] mu_t;

   always_comb begin
      // segment is the first k whose end (first_end << k) - 1 covers the magnitude
      seg_a = 4'd8;
      seg_m = 4'd8;
      for (int k = 7; k >= 0; k--) begin
         if (in_data.mag <= 14'((g711cc_pkg::A_FIRST_END << k) - 1)) begin
            seg_a = 4'(k);
         end
         if (in_data.mag <= 14'((g711cc_pkg::MU_FIRST_END << k) - 1)) begin
            seg_m = 4'(k);
         end
      end
      sh_a = (seg_a < 4'd2) ? 4'd1 : seg_a;
      sh_m = seg_m + 4'd1;
      mant_a = 4'(in_data.mag >> sh_a);
      mant_m = 4'(in_data.mag >> sh_m);

      a_base = 15'({in_data.dec_mant, 4'h0}) + g711cc_pkg::A_DEC_BIAS;
      a_t = (in_data.dec_seg == 3'd0) ? 15'({in_data.dec_mant, 4'h8})
                                      : a_base << (in_data.dec_seg - 3'd1);
      mu_t = (15'({in_data.dec_mant, 3'b000}) + g711cc_pkg::MU_DEC_BIAS) << in_data.dec_seg;

      data_in = '0;
      data_in.mask = in_data.mask;
      case (in_data.cmd)
         g711cc_pkg::CMD_LIN_TO_A: begin
            data_in.code = seg_a[3] ? g711cc_pkg::TOP_CODE : {1'b0, seg_a[2:0], mant_a};
         end
         g711cc_pkg::CMD_LIN_TO_MU: begin
            data_in.code = seg_m[3] ? g711cc_pkg::TOP_CODE : {1'b0, seg_m[2:0], mant_m};
         end
         g711cc_pkg::CMD_A_TO_LIN: begin
            data_in.pcm_mag = a_t;
            data_in.pcm_neg = in_data.dec_neg;
         end
         g711cc_pkg::CMD_MU_TO_LIN: begin
            data_in.pcm_mag = mu_t - g711cc_pkg::MU_DEC_BIAS;
            data_in.pcm_neg = in_data.dec_neg;
         end
         g711cc_pkg::CMD_A_TO_MU, g711cc_pkg::CMD_MU_TO_A: begin
            data_in.code = {1'b0, in_data.xcode};
         end
         default: begin
         end
      endcase
   end

   assign in_stall = valid_ff & out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule
`default_nettype wire

// ----- hdl/g711cc_out.sv -----
`default_nettype none
module g711cc_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_stall,
   input  wire g711cc_pkg::seg_type in_data,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output logic signed [15:0]       pcm_out,
   output logic [7:0]               code_out
);

   logic        valid_ff;
   logic        valid_in;
   logic [15:0] pcm_ff;
   logic [15:0] pcm_in;
   logic [7:0]  code_ff;
   logic [7:0]  code_in;
   logic [15:0] mag16;

   always_comb begin
      mag16 = {1'b0, in_data.pcm_mag};
      pcm_in = in_data.pcm_neg ? (16'd0 - mag16) : mag16;
      // mask and code are both zero for the decode and unused commands
      code_in = in_data.code ^ in_data.mask;
   end

   assign in_stall = valid_ff & out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         pcm_ff <= pcm_in;
         code_ff <= code_in;
      end
   end

   assign out_valid = valid_ff;
   assign pcm_out = signed'(pcm_ff);
   assign code_out = code_ff;

endmodule
`default_nettype wire

// ----- hdl/g711_companding_codec.sv -----
// G.711 A-law / mu-law companding unit.
// Request channel: req_valid, req_stall, req_command, req_sample, req_code_in.
// A transfer happens at a rising edge with req_valid high and req_stall low.
// Commands: linear to A-law, linear to mu-law, A-law to linear, mu-law to
// linear, A-law to mu-law, mu-law to A-law; the other two codes give zeros.
// Response channel: rsp_valid, rsp_stall, rsp_pcm_out, rsp_code_out, one
// response per request, in request order.
// Pipeline: three register stages (input prep and table lookup, segment search
// and mantissa/decode shift, sign and mask apply); the response is driven
// straight from the sign and mask register.
// Throughput: one request per cycle while rsp_stall stays low.
// When the receiver holds rsp_stall, the response holds steady and the stages
// behind it keep filling; req_stall rises once the pipeline is full, and it is
// low in any cycle with rsp_stall low.
// Reset (synchronous, active high) empties the pipeline; no data is kept.
`default_nettype none
module g711_companding_codec (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [15:0] req_sample,
   input  wire logic [7:0]         req_code_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_pcm_out,
   output logic [7:0]              rsp_code_out
);

   logic                 p_valid;
   logic                 p_stall;
   g711cc_pkg::prep_type p_data;
   logic                 s_valid;
   logic                 s_stall;
   g711cc_pkg::seg_type  s_data;

   g711cc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .command   (req_command),
      .sample    (req_sample),
      .code_in   (req_code_in),
      .out_valid (p_valid),
      .out_stall (p_stall),
      .out_data  (p_data)
   );

   g711cc_seg u_seg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_stall  (p_stall),
      .in_data   (p_data),
      .out_valid (s_valid),
      .out_stall (s_stall),
      .out_data  (s_data)
   );

   g711cc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_stall  (s_stall),
      .in_data   (s_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .pcm_out   (rsp_pcm_out),
      .code_out  (rsp_code_out)
   );

endmodule
`default_nettype wire

// ----- hdl/g711cc_checker.sv -----
`default_nettype none
module g711cc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_pcm_out,
   input wire logic [7:0]         rsp_code_out
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pcm_out) && $stable(rsp_code_out))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // back pressure only comes from a stalled receiver
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled with free receiver");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing three cycles after transfer");

   // a response carries either a sample or a code byte
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pcm_out == 16'sd0 || rsp_code_out == 8'd0))
      else $error("both response fields nonzero");

endmodule

bind g711_companding_codec g711cc_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_pcm_out  (rsp_pcm_out),
   .rsp_code_out (rsp_code_out)
);
`default_nettype wire
